// File: design/tsdlp_pkg.sv
`timescale 1ns / 1ps
package tsdlp_pkg;

  typedef enum logic [1:0] {
    PH_TAG = 2'd0,
    PH_LEN = 2'd1,
    PH_PAY = 2'd2
  } phase_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  localparam logic [3:0] K_OTHER = 4'd0;
  localparam logic [3:0] K_CA    = 4'd1;
  localparam logic [3:0] K_SVC   = 4'd2;
  localparam logic [3:0] K_SEV   = 4'd3;
  localparam logic [3:0] K_SID   = 4'd4;
  localparam logic [3:0] K_NET   = 4'd5;
  localparam logic [3:0] K_SYS   = 4'd6;
  localparam logic [3:0] K_TSI   = 4'd7;
  localparam logic [3:0] K_CMP   = 4'd8;
  localparam logic [3:0] K_AUD   = 4'd9;

  localparam int CapDepth = 12;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        block_start;
    logic        block_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  tag_code;
    logic [7:0]  desc_length;
    logic [1:0]  status;
    logic [3:0]  desc_kind;
    logic [15:0] word_field;
    logic [12:0] pid_field;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [7:0]  byte_c;
    logic [6:0]  flag_bits;
    logic [23:0] language_one;
    logic [23:0] language_two;
  } out_item_t;

  function automatic logic [3:0] kind_of(input logic [7:0] tag);
    logic [3:0] k;
    unique case (tag)
      8'h09:   k = K_CA;
      8'h48:   k = K_SVC;
      8'h4D:   k = K_SEV;
      8'h52:   k = K_SID;
      8'h40:   k = K_NET;
      8'hFE:   k = K_SYS;
      8'hCD:   k = K_TSI;
      8'h50:   k = K_CMP;
      8'hC4:   k = K_AUD;
      default: k = K_OTHER;
    endcase
    return k;
  endfunction

endpackage

// File: design/tsdlp_if.sv
`timescale 1ns / 1ps
interface tsdlp_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// File: design/ts_descriptor_loop_parser_unit.sv
`timescale 1ns / 1ps
// Descriptor loop parser: takes one loop byte per item and emits one record
// when a descriptor completes, is rejected on its length byte, or is cut off
// by the loop end. One byte is accepted every cycle; a record appears in the
// cycle after the byte that finishes it, held in an output register that
// stalls input only while a record waits and the downstream is not ready.
module ts_descriptor_loop_parser_unit (
  input logic clk,
  input logic rst,
  tsdlp_if.sink   in_ch,
  tsdlp_if.source out_ch
);
  import tsdlp_pkg::*;

  phase_t         phase, phase_next;
  logic           stopped, stopped_next;
  logic [7:0]     cur_tag, cur_tag_next;
  logic [7:0]     cur_len, cur_len_next;
  logic [7:0]     pay_idx, pay_idx_next;
  logic [7:0]     len1, len1_next;
  logic [7:0]     len2, len2_next;
  logic [12*8-1:0] cap, cap_next;
  out_item_t      rec_chk, rec_next, out_rec;
  logic           emit, out_valid;
  logic           take;
  in_item_t       it;
  logic [7:0]     off;
  logic [8:0]     idx_inc;
  logic [7:0]     len1_upd, len2_upd;
  logic [12*8-1:0] cap_upd;

  assign it        = in_ch.item;
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign take      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.item  = out_rec;

  tsdlp_check u_check (
    .tag(cur_tag), .len(cur_len), .l1(len1_upd), .l2(len2_upd), .cap(cap_upd),
    .rec(rec_chk)
  );

  assign off     = (cur_tag == 8'h4D) ? 8'd3 : 8'd1;
  assign idx_inc = {1'b0, pay_idx} + 9'd1;

  // place the byte in the capture store and track the string lengths
  always_comb begin
    cap_upd  = cap;
    len1_upd = len1;
    len2_upd = len2;
    if (pay_idx < 8'(CapDepth)) cap_upd[pay_idx[3:0]*8 +: 8] = it.data_byte;
    if (pay_idx == off) len1_upd = it.data_byte;
    else if (pay_idx > off && {1'b0, pay_idx} == {1'b0, off} + 9'd1 + {1'b0, len1})
      len2_upd = it.data_byte;
  end

  // step the parser on one byte
  always_comb begin
    phase_next   = phase;
    stopped_next = stopped;
    cur_tag_next = cur_tag;
    cur_len_next = cur_len;
    pay_idx_next = pay_idx;
    len1_next    = len1;
    len2_next    = len2;
    cap_next     = cap;
    emit         = 1'b0;
    rec_next     = '0;
    if (it.block_start) begin
      stopped_next = 1'b0;
    end
    if (it.block_start || !stopped) begin
      unique case (it.block_start ? PH_TAG : phase)
        PH_LEN: begin
          cur_len_next = it.data_byte;
          rec_next.tag_code    = cur_tag;
          rec_next.desc_length = it.data_byte;
          rec_next.desc_kind   = kind_of(cur_tag);
          if (it.data_byte == 8'd0) begin
            emit = 1'b1;
            rec_next.status = ST_BAD;
            stopped_next = 1'b1;
            phase_next = PH_TAG;
          end else if (it.block_end) begin
            emit = 1'b1;
            rec_next.status = ST_TRUNC;
            stopped_next = 1'b1;
            phase_next = PH_TAG;
          end else begin
            phase_next = PH_PAY;
          end
        end
        PH_PAY: begin
          cap_next     = cap_upd;
          len1_next    = len1_upd;
          len2_next    = len2_upd;
          pay_idx_next = idx_inc[7:0];
          if (idx_inc == {1'b0, cur_len}) begin
            emit = 1'b1;
            rec_next = rec_chk;
            phase_next = PH_TAG;
            if (rec_chk.status != ST_OK || it.block_end) stopped_next = 1'b1;
          end else if (it.block_end) begin
            emit = 1'b1;
            rec_next.tag_code    = cur_tag;
            rec_next.desc_length = cur_len;
            rec_next.desc_kind   = kind_of(cur_tag);
            rec_next.status      = ST_TRUNC;
            stopped_next = 1'b1;
            phase_next = PH_TAG;
          end
        end
        default: begin
          cur_tag_next = it.data_byte;
          cur_len_next = 8'd0;
          pay_idx_next = 8'd0;
          len1_next    = 8'd0;
          len2_next    = 8'd0;
          phase_next   = PH_LEN;
          if (it.block_end) begin
            emit = 1'b1;
            rec_next.tag_code  = it.data_byte;
            rec_next.desc_kind = kind_of(it.data_byte);
            rec_next.status    = ST_TRUNC;
            stopped_next = 1'b1;
            phase_next = PH_TAG;
          end
        end
      endcase
    end
  end

  // hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_TAG;
      stopped <= 1'b1;
      cur_tag <= '0;
      cur_len <= '0;
      pay_idx <= '0;
      len1    <= '0;
      len2    <= '0;
    end else if (take) begin
      phase   <= phase_next;
      stopped <= stopped_next;
      cur_tag <= cur_tag_next;
      cur_len <= cur_len_next;
      pay_idx <= pay_idx_next;
      len1    <= len1_next;
      len2    <= len2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) cap <= cap_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= emit;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) out_rec <= rec_next;
  end
endmodule

// File: design/tsdlp_check.sv
`timescale 1ns / 1ps
// Format rules for a complete descriptor (length at least one).
module tsdlp_check (
  input  logic [7:0]           tag,
  input  logic [7:0]           len,
  input  logic [7:0]           l1,
  input  logic [7:0]           l2,
  input  logic [12*8-1:0]      cap,
  output tsdlp_pkg::out_item_t rec
);
  import tsdlp_pkg::*;

  logic [7:0] p [CapDepth];
  logic       ok;
  logic [9:0] l1w, l2w, lenw;
  out_item_t  f;

  // unpack captured bytes, first byte in the low lane
  always_comb begin
    for (int i = 0; i < CapDepth; i++) p[i] = cap[i*8 +: 8];
  end

  assign l1w  = {2'b00, l1};
  assign l2w  = {2'b00, l2};
  assign lenw = {2'b00, len};

  // check the rules and decode the fields of each kind
  always_comb begin
    ok = 1'b1;
    f  = '0;
    unique case (kind_of(tag))
      K_CA: begin
        if (len < 8'd4 || (p[2] & 8'hE0) != 8'hE0) ok = 1'b0;
        f.word_field = {p[0], p[1]};
        f.pid_field  = {p[2][4:0], p[3]};
      end
      K_SVC: begin
        if (len < 8'd3) ok = 1'b0;
        if (l1 != 8'd0 && 10'd2 + l1w >= lenw) ok = 1'b0;
        if (l2 != 8'd0 && 10'd3 + l1w + l2w > lenw) ok = 1'b0;
        f.byte_a = p[0];
        f.byte_b = l1;
        f.byte_c = l2;
      end
      K_SEV: begin
        if (len < 8'd5) ok = 1'b0;
        if (l1 != 8'd0 && 10'd4 + l1w >= lenw) ok = 1'b0;
        if (l2 != 8'd0 && 10'd5 + l1w + l2w > lenw) ok = 1'b0;
        f.byte_b       = l1;
        f.byte_c       = l2;
        f.language_one = {p[0], p[1], p[2]};
      end
      K_SID: begin
        if (len != 8'd1) ok = 1'b0;
        f.byte_a = p[0];
      end
      K_SYS: begin
        if (len < 8'd2) ok = 1'b0;
        f.flag_bits = {5'd0, p[0][7:6]};
        f.byte_a    = p[0] & 8'h3F;
        f.byte_b    = p[1];
      end
      K_TSI: begin
        if (len < 8'd2 || 10'd2 + {4'd0, p[1][7:2]} > lenw) ok = 1'b0;
        f.byte_a = p[0];
        f.byte_b = {2'b00, p[1][7:2]};
      end
      K_CMP: begin
        if (len < 8'd6 || (p[0] & 8'h0F) != 8'h01) ok = 1'b0;
        f.byte_a       = p[1];
        f.byte_b       = p[2];
        f.language_one = {p[3], p[4], p[5]};
      end
      K_AUD: begin
        if (len < 8'd9 || (p[0] & 8'h0F) != 8'h02) ok = 1'b0;
        if ((p[5] & 8'h80) != 8'h00) begin
          if (len < 8'd12) ok = 1'b0;
          f.language_two = {p[9], p[10], p[11]};
        end
        f.byte_a       = p[1];
        f.byte_b       = p[2];
        f.byte_c       = p[3];
        f.word_field   = {8'd0, p[4]};
        f.flag_bits    = p[5][7:1];
        f.language_one = {p[6], p[7], p[8]};
      end
      default: ok = 1'b1;
    endcase
    if (!ok) f = '0;
    rec             = f;
    rec.tag_code    = tag;
    rec.desc_length = len;
    rec.desc_kind   = kind_of(tag);
    rec.status      = ok ? ST_OK : ST_BAD;
  end
endmodule

// File: design/tsdlp_checker.sv
`timescale 1ns / 1ps
module tsdlp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] status,
  input logic [3:0] desc_kind
);
  import tsdlp_pkg::*;

  // a stalled record holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("record dropped while stalled");

  // input is open whenever the output stage is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // status never takes the unused code
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("bad status code");

  // kind stays in its range
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> desc_kind <= K_AUD)
    else $error("bad kind");
endmodule

bind ts_descriptor_loop_parser_unit tsdlp_checker u_tsdlp_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.item.status), .desc_kind(out_ch.item.desc_kind)
);

// File: tb/ts_descriptor_loop_parser_unit_tb.sv
`timescale 1ns / 1ps
module ts_descriptor_loop_parser_unit_tb;
  import tsdlp_pkg::*;

  localparam logic [7:0] TAG_CA  = 8'h09;
  localparam logic [7:0] TAG_SVC = 8'h48;
  localparam logic [7:0] TAG_SEV = 8'h4D;
  localparam logic [7:0] TAG_SID = 8'h52;
  localparam logic [7:0] TAG_NET = 8'h40;
  localparam logic [7:0] TAG_SYS = 8'hFE;
  localparam logic [7:0] TAG_TSI = 8'hCD;
  localparam logic [7:0] TAG_CMP = 8'h50;
  localparam logic [7:0] TAG_AUD = 8'hC4;
  localparam int IdleLimit = 4000;
  localparam int ByteTarget = 1450;

  // Predicts descriptor records from loop bytes and holds those still owed
  class desc_scoreboard;
    out_item_t   records_due[$];
    int          errors;
    phase_t      phase;
    bit          stopped;
    logic [7:0]  tag, len, idx, l1, l2;
    logic [7:0]  cap[CapDepth];

    function new();
      errors = 0;
      phase = PH_TAG;
      stopped = 1;
      tag = 0; len = 0; idx = 0; l1 = 0; l2 = 0;
      foreach (cap[i]) cap[i] = 0;
    endfunction

    function logic [3:0] tag_kind(logic [7:0] t);
      case (t)
        TAG_CA:  return K_CA;
        TAG_SVC: return K_SVC;
        TAG_SEV: return K_SEV;
        TAG_SID: return K_SID;
        TAG_NET: return K_NET;
        TAG_SYS: return K_SYS;
        TAG_TSI: return K_TSI;
        TAG_CMP: return K_CMP;
        TAG_AUD: return K_AUD;
        default: return K_OTHER;
      endcase
    endfunction

    function logic [23:0] lang_at(int at);
      return {cap[at], cap[at+1], cap[at+2]};
    endfunction

    function out_item_t bare_record(logic [1:0] st);
      out_item_t r;
      r = '0;
      r.tag_code = tag;
      r.desc_length = len;
      r.status = st;
      r.desc_kind = tag_kind(tag);
      return r;
    endfunction

    // Apply the format rules of a complete descriptor
    function out_item_t judge();
      out_item_t r;
      bit ok;
      int n, a, b;
      n = len; a = l1; b = l2;
      ok = 1;
      r = bare_record(ST_OK);
      case (tag_kind(tag))
        K_CA: begin
          if (n < 4 || (cap[2] & 8'hE0) != 8'hE0) ok = 0;
          else begin
            r.word_field = {cap[0], cap[1]};
            r.pid_field = {cap[2][4:0], cap[3]};
          end
        end
        K_SVC: begin
          if (n < 3 || (a > 0 && 2 + a >= n) || (b > 0 && 3 + a + b > n)) ok = 0;
          else begin
            r.byte_a = cap[0]; r.byte_b = l1; r.byte_c = l2;
          end
        end
        K_SEV: begin
          if (n < 5 || (a > 0 && 4 + a >= n) || (b > 0 && 5 + a + b > n)) ok = 0;
          else begin
            r.byte_b = l1; r.byte_c = l2; r.language_one = lang_at(0);
          end
        end
        K_SID: begin
          if (n != 1) ok = 0;
          else r.byte_a = cap[0];
        end
        K_SYS: begin
          if (n < 2) ok = 0;
          else begin
            r.flag_bits = 7'(cap[0][7:6]);
            r.byte_a = {2'b00, cap[0][5:0]};
            r.byte_b = cap[1];
          end
        end
        K_TSI: begin
          if (n < 2 || 2 + int'(cap[1][7:2]) > n) ok = 0;
          else begin
            r.byte_a = cap[0];
            r.byte_b = {2'b00, cap[1][7:2]};
          end
        end
        K_CMP: begin
          if (n < 6 || cap[0][3:0] != 4'h1) ok = 0;
          else begin
            r.byte_a = cap[1]; r.byte_b = cap[2]; r.language_one = lang_at(3);
          end
        end
        K_AUD: begin
          if (n < 9 || cap[0][3:0] != 4'h2 || (cap[5][7] && n < 12)) ok = 0;
          else begin
            if (cap[5][7]) r.language_two = lang_at(9);
            r.byte_a = cap[1]; r.byte_b = cap[2]; r.byte_c = cap[3];
            r.word_field = {8'h00, cap[4]};
            r.flag_bits = cap[5][7:1];
            r.language_one = lang_at(6);
          end
        end
        default: ;
      endcase
      if (!ok) begin
        r = bare_record(ST_BAD);
        stopped = 1;
      end
      return r;
    endfunction

    // Advance the parser by one accepted byte
    function void note_byte(in_item_t it);
      int i, off;
      if (it.block_start) begin
        stopped = 0;
        phase = PH_TAG;
      end
      if (stopped) return;
      if (phase == PH_LEN) begin
        len = it.data_byte;
        if (len == 0) begin
          records_due.insert(records_due.size(), bare_record(ST_BAD));
          stopped = 1;
          phase = PH_TAG;
        end else if (it.block_end) begin
          records_due.insert(records_due.size(), bare_record(ST_TRUNC));
          stopped = 1;
          phase = PH_TAG;
        end else begin
          phase = PH_PAY;
        end
      end else if (phase == PH_PAY) begin
        i = idx;
        off = (tag == TAG_SEV) ? 3 : 1;
        if (i < CapDepth) cap[i] = it.data_byte;
        if (i == off) l1 = it.data_byte;
        else if (i > off && i == off + 1 + int'(l1)) l2 = it.data_byte;
        idx = 8'(i + 1);
        if (i + 1 == int'(len)) begin
          records_due.insert(records_due.size(), judge());
          phase = PH_TAG;
          if (it.block_end) stopped = 1;
        end else if (it.block_end) begin
          records_due.insert(records_due.size(), bare_record(ST_TRUNC));
          stopped = 1;
          phase = PH_TAG;
        end
      end else begin
        tag = it.data_byte;
        len = 0; idx = 0; l1 = 0; l2 = 0;
        phase = PH_LEN;
        if (it.block_end) begin
          records_due.insert(records_due.size(), bare_record(ST_TRUNC));
          stopped = 1;
          phase = PH_TAG;
        end
      end
    endfunction

    function void compare(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_record(out_item_t got);
      out_item_t e;
      if (records_due.size() == 0) begin
        $error("record with tag 0x%0h arrived with none owed", got.tag_code);
        errors++;
        return;
      end
      e = records_due.pop_front();
      compare("tag_code", e.tag_code, got.tag_code);
      compare("desc_length", e.desc_length, got.desc_length);
      compare("status", e.status, got.status);
      compare("desc_kind", e.desc_kind, got.desc_kind);
      compare("word_field", e.word_field, got.word_field);
      compare("pid_field", e.pid_field, got.pid_field);
      compare("byte_a", e.byte_a, got.byte_a);
      compare("byte_b", e.byte_b, got.byte_b);
      compare("byte_c", e.byte_c, got.byte_c);
      compare("flag_bits", e.flag_bits, got.flag_bits);
      compare("language_one", e.language_one, got.language_one);
      compare("language_two", e.language_two, got.language_two);
    endfunction
  endclass

  logic clk;
  logic rst;
  tsdlp_if #(.item_t(in_item_t))  in_ch ();
  tsdlp_if #(.item_t(out_item_t)) out_ch ();

  ts_descriptor_loop_parser_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  desc_scoreboard sb;
  int burst_left;
  int bytes_sent;
  int idle_cycles;
  int rx_cycle;
  int rx_hold;
  int rx_rate;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Sample both handshakes mid-cycle; the items move at the next rising edge
  always @(negedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) sb.check_record(out_ch.item);
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.item);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: varying stall rate, with one long hold-off part way through
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_rate = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(20, 90);
    if (rx_cycle == 600) rx_hold = 600;
    if (rx_hold > 0) begin
      rx_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) < rx_rate);
    end
  end

  // Offer one byte and hold it until taken; bursts separated by random gaps
  task automatic push_byte(logic [7:0] b, bit s, bit e);
    in_item_t it;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    it.data_byte = b;
    it.block_start = s;
    it.block_end = e;
    in_ch.valid <= 1'b1;
    in_ch.item <= it;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // Send a loop of bytes with start on the first and end on the last
  task automatic send_loop(logic [7:0] q[$]);
    foreach (q[i]) push_byte(q[i], i == 0, i == q.size() - 1);
  endtask

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Append one descriptor, mostly well formed for its tag
  task automatic add_desc(logic [7:0] t, bit legal, ref logic [7:0] q[$]);
    logic [7:0] p[$];
    int n, a, b;
    if (!legal) begin
      n = $urandom_range(0, 8);
      repeat (n) p.insert(p.size(), rnd_byte());
    end else begin
      case (t)
        TAG_CA: begin
          repeat ($urandom_range(4, 7)) p.insert(p.size(), rnd_byte());
          p[2] = p[2] | 8'hE0;
        end
        TAG_SVC, TAG_SEV: begin
          a = $urandom_range(0, 3); b = $urandom_range(0, 3);
          n = ((t == TAG_SEV) ? 5 : 3) + a + b;
          repeat (n) p.insert(p.size(), rnd_byte());
          p[(t == TAG_SEV) ? 3 : 1] = 8'(a);
          p[((t == TAG_SEV) ? 4 : 2) + a] = 8'(b);
        end
        TAG_SID: p.insert(p.size(), rnd_byte());
        TAG_NET: repeat ($urandom_range(1, 8)) p.insert(p.size(), rnd_byte());
        TAG_SYS: repeat ($urandom_range(2, 4)) p.insert(p.size(), rnd_byte());
        TAG_TSI: begin
          a = $urandom_range(0, 3);
          repeat (2 + a + $urandom_range(0, 2)) p.insert(p.size(), rnd_byte());
          p[1] = {6'(a), p[1][1:0]};
        end
        TAG_CMP: begin
          repeat ($urandom_range(6, 9)) p.insert(p.size(), rnd_byte());
          p[0] = {p[0][7:4], 4'h1};
        end
        TAG_AUD: begin
          b = $urandom_range(0, 1);
          repeat (b ? $urandom_range(12, 13) : $urandom_range(9, 10))
            p.insert(p.size(), rnd_byte());
          p[0] = {p[0][7:4], 4'h2};
          p[5][7] = 1'(b);
        end
        default: begin
          n = ($urandom_range(0, 49) == 0) ? $urandom_range(200, 255) : $urandom_range(1, 10);
          repeat (n) p.insert(p.size(), rnd_byte());
        end
      endcase
    end
    q.insert(q.size(), t);
    q.insert(q.size(), 8'(p.size()));
    foreach (p[i]) q.insert(q.size(), p[i]);
  endtask

  function automatic logic [7:0] pick_tag();
    logic [7:0] known[9];
    known = '{TAG_CA, TAG_SVC, TAG_SEV, TAG_SID, TAG_NET,
              TAG_SYS, TAG_TSI, TAG_CMP, TAG_AUD};
    if ($urandom_range(0, 9) == 0) return rnd_byte();
    return known[$urandom_range(0, 8)];
  endfunction

  initial begin
    logic [7:0] q[$];
    int pick;
    sb = new();
    burst_left = 0;
    bytes_sent = 0;
    idle_cycles = 0;
    rx_cycle = 0;
    rx_hold = 0;
    rx_rate = 100;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.item = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: bytes while stopped, zero length, start and end together
    push_byte(8'hFF, 0, 0);
    push_byte(8'h00, 0, 1);
    send_loop('{TAG_SVC, 8'h00});
    send_loop('{8'hFF});
    send_loop('{TAG_CA, 8'hFF});
    send_loop('{TAG_CMP, 8'h06, 8'hF1, 8'h00});
    send_loop('{TAG_SID, 8'h01, 8'hFF, TAG_SYS, 8'h02, 8'hC0, 8'h00});
    send_loop('{TAG_SID, 8'h02, 8'h55, 8'hAA, 8'h00});

    // Random: well-formed loops, truncated loops and noise
    while (bytes_sent < ByteTarget) begin
      pick = $urandom_range(0, 99);
      q.delete();
      if (pick < 5) begin
        repeat ($urandom_range(1, 6))
          push_byte(rnd_byte(), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      end else begin
        repeat ($urandom_range(1, 4)) add_desc(pick_tag(), $urandom_range(0, 9) != 0, q);
        if (pick < 15) q = q[0:$urandom_range(0, q.size() - 1)];
        send_loop(q);
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.records_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.records_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
design/tsdlp_pkg.sv
design/tsdlp_if.sv
design/tsdlp_check.sv
design/ts_descriptor_loop_parser_unit.sv
design/tsdlp_checker.sv
tb/ts_descriptor_loop_parser_unit_tb.sv
